[rtl/core/crapwow_hash_32_assert.svh]
// assertion macros for the crapwow hash core
// no dependencies; included by the files that carry assertions
`ifndef CRAPWOW_HASH_32_ASSERT_SVH
`define CRAPWOW_HASH_32_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define CW32_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cw32 assertion failed");
// next-cycle implication, checked out of reset
`define CW32_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cw32 assertion failed");
`else
`define CW32_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define CW32_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/core/cw32_pkg.sv]
// shared types and constants for the crapwow hash core
// no dependencies; used by cw32_ctrl, cw32_dpath and crapwow_hash_32
package cw32_pkg;

   localparam int WORD_W       = 32;
   localparam int COUNT_W      = 3;
   localparam int REQ_TDATA_W  = 40;
   localparam int RSP_TDATA_W  = 32;

   localparam logic [WORD_W-1:0]  MULT_M = 32'h5755_9429;
   localparam logic [WORD_W-1:0]  MULT_N = 32'h5052_acdb;
   localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_MIX_HK,
      ST_MIX_T,
      ST_MIX_MUL,
      ST_EMIT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;   // take the input word into the multiplier
      logic fold;     // xor the product into the accumulators
      logic mix_hk;   // form h and k, clear the key state
      logic mix_t;    // form the final mix operand
      logic mix_mul;  // multiply the mix operand by n
      logic emit;     // load the result register
   } cmd_type;

endpackage

[rtl/core/crapwow_hash_32.sv]
// CrapWow 32-bit hash core. Each key word is first multiplied through the single 32x32 multiplier,
// then its product is folded into the accumulators. A last word then runs the final mixing steps
// in order (h/k formation, mix operand, second multiply through the same multiplier, result
// register). The next key's first word is accepted while the previous hash still waits in the
// output register. The seed register is written through csr_wen/csr_wdata and survives between
// keys; the user is to write it only while the core is idle, the block itself does not enforce it.
// top level; depends on cw32_pkg, cw32_ctrl, cw32_dpath and crapwow_hash_32_assert.svh
`include "crapwow_hash_32_assert.svh"

module crapwow_hash_32 (
   input  logic                                clock,
   input  logic                                reset,
   // transaction in: one key word
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cw32_pkg::REQ_TDATA_W-1:0]    req_tdata,  // data_word[31:0], byte_count[34:32]
   input  logic                                req_tlast,
   // transaction out: one hash
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cw32_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // hash[31:0]
   // seed register write
   input  logic                                csr_wen,
   input  logic [cw32_pkg::WORD_W-1:0]         csr_wdata
);
   import cw32_pkg::*;

   cmd_type cmd;

   // sequencing
   cw32_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   // arithmetic
   cw32_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .data_word  (req_tdata[WORD_W-1:0]),
      .byte_count (req_tdata[WORD_W+COUNT_W-1:WORD_W]),
      .last       (req_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .hash       (rsp_tdata)
   );

   // every accepted word is folded in the following cycle
   `CW32_ASSERT_NEXT(a_fold_after_accept, clock, reset, req_tvalid && req_tready, cmd.fold)
   // loading the result register raises the result valid flag
   `CW32_ASSERT_NEXT(a_valid_after_emit, clock, reset, cmd.emit, rsp_tvalid)
   // at most one datapath command per cycle
   `CW32_ASSERT_NOW(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd))

endmodule

[rtl/core/cw32_ctrl.sv]
// controller state machine for the crapwow hash core
// depends on cw32_pkg; drives cw32_dpath through cmd_type
module cw32_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tlast,
   output logic              req_tready,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output cw32_pkg::cmd_type cmd
);
   import cw32_pkg::*;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      emit_ok;

   // result register is free or being drained this cycle
   assign emit_ok = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            state_in = last_ff ? ST_MIX_HK : ST_IDLE;
         end
         ST_MIX_HK: begin
            state_in = ST_MIX_T;
         end
         ST_MIX_T: begin
            state_in = ST_MIX_MUL;
         end
         ST_MIX_MUL: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_ok) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
         end
         ST_MIX_HK: begin
            cmd.mix_hk = 1'b1;
         end
         ST_MIX_T: begin
            cmd.mix_t = 1'b1;
         end
         ST_MIX_MUL: begin
            cmd.mix_mul = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = emit_ok;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // last mark of the word in flight, result valid flag
   assign last_in      = cmd.accept ? req_tlast : last_ff;
   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/core/cw32_dpath.sv]
// datapath for the crapwow hash core: shared multiplier, accumulators, final mix
// depends on cw32_pkg; controlled by cw32_ctrl
module cw32_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  cw32_pkg::cmd_type             cmd,
   input  logic [cw32_pkg::WORD_W-1:0]   data_word,
   input  logic [cw32_pkg::COUNT_W-1:0]  byte_count,
   input  logic                          last,
   input  logic                          csr_wen,
   input  logic [cw32_pkg::WORD_W-1:0]   csr_wdata,
   output logic [cw32_pkg::WORD_W-1:0]   hash
);
   import cw32_pkg::*;

   logic [WORD_W-1:0]   seed_ff;
   logic [WORD_W-1:0]   acc_high_ff, acc_high_in;
   logic [WORD_W-1:0]   acc_low_ff, acc_low_in;
   logic [WORD_W-1:0]   total_ff, total_in;
   logic                odd_ff, odd_in;
   logic                swap_ff;
   logic [2*WORD_W-1:0] prod_ff;
   logic [WORD_W-1:0]   h_ff, k_ff, op_ff, hash_ff;

   logic [COUNT_W-1:0]  eff_count;
   logic                full_word;
   logic [WORD_W-1:0]   byte_mask;
   logic [WORD_W-1:0]   mult_a, mult_b;
   logic [2*WORD_W-1:0] prod;

   // a non-last word always counts as four bytes
   assign eff_count = (!last || byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
   assign full_word = (eff_count == FULL_COUNT);

   // keep only the valid bytes of a partial word
   always_comb begin
      case (eff_count)
         3'd0:    byte_mask = 32'h0000_0000;
         3'd1:    byte_mask = 32'h0000_00ff;
         3'd2:    byte_mask = 32'h0000_ffff;
         3'd3:    byte_mask = 32'h00ff_ffff;
         default: byte_mask = 32'hffff_ffff;
      endcase
   end

   // shared 32x32 multiplier: input word or final mix operand
   assign mult_a = cmd.mix_mul ? op_ff : (data_word & byte_mask);
   assign mult_b = (cmd.mix_mul || (full_word && !odd_ff)) ? MULT_N : MULT_M;
   assign prod   = {{WORD_W{1'b0}}, mult_a} * {{WORD_W{1'b0}}, mult_b};

   // key state update
   always_comb begin
      acc_high_in = acc_high_ff;
      acc_low_in  = acc_low_ff;
      total_in    = total_ff;
      odd_in      = odd_ff;
      if (cmd.accept) begin
         total_in = total_ff + {{(WORD_W-COUNT_W){1'b0}}, eff_count};
         if (full_word) odd_in = ~odd_ff;
      end
      if (cmd.fold) begin
         if (swap_ff) begin
            acc_high_in = acc_high_ff ^ prod_ff[WORD_W-1:0];
            acc_low_in  = acc_low_ff ^ prod_ff[2*WORD_W-1:WORD_W];
         end else begin
            acc_low_in  = acc_low_ff ^ prod_ff[WORD_W-1:0];
            acc_high_in = acc_high_ff ^ prod_ff[2*WORD_W-1:WORD_W];
         end
      end
      if (cmd.mix_hk) begin
         acc_high_in = '0;
         acc_low_in  = '0;
         total_in    = '0;
         odd_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= '0;
         acc_high_ff <= '0;
         acc_low_ff  <= '0;
         total_ff    <= '0;
         odd_ff      <= 1'b0;
      end else begin
         if (csr_wen) seed_ff <= csr_wdata;
         acc_high_ff <= acc_high_in;
         acc_low_ff  <= acc_low_in;
         total_ff    <= total_in;
         odd_ff      <= odd_in;
      end
   end

   // product register and final mix pipeline
   always_ff @(posedge clock) begin
      if (cmd.accept || cmd.mix_mul) prod_ff <= prod;
      if (cmd.accept) swap_ff <= full_word && !odd_ff;
      if (cmd.mix_hk) begin
         h_ff <= acc_high_ff ^ total_ff;
         k_ff <= acc_low_ff ^ (total_ff + seed_ff + MULT_N);
      end
      if (cmd.mix_t) op_ff <= h_ff ^ (k_ff + MULT_N);
      if (cmd.emit) begin
         hash_ff <= k_ff ^ h_ff ^ prod_ff[WORD_W-1:0] ^ prod_ff[2*WORD_W-1:WORD_W];
      end
   end

   assign hash = hash_ff;

endmodule

[tb/tb.sv]
// testbench for crapwow_hash_32: directed key words, then random keys under several seeds
// depends on cw32_pkg and the crapwow_hash_32 top level; self-checking against its own predictor
`timescale 1ns / 1ps

module tb;
   import cw32_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned SETTLE_TICKS = 12;
   localparam int unsigned N_DIRECTED   = 19;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  count;
      logic        last;
   } key_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // data_word[31:0], byte_count[34:32]
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;       // hash[31:0]
   logic        csr_wen = 1'b0;
   logic [WORD_W-1:0] csr_wdata = '0;

   // predictor state for the key in flight
   logic [31:0] acc_h, acc_k, key_bytes, seed_reg;
   logic        odd_word;
   logic [31:0] expected_hashes [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          calm = 1'b0;

   // directed words: empty key, partial tails, counts above four, ignored counts
   key_word_type directed_words [N_DIRECTED] = '{
      '{32'h0000_0000, 3'd0, 1'b1},
      '{32'hffff_ffff, 3'd4, 1'b1},
      '{32'hffff_ffff, 3'd1, 1'b1},
      '{32'hffff_ffff, 3'd2, 1'b1},
      '{32'hffff_ffff, 3'd3, 1'b1},
      '{32'h1234_5678, 3'd5, 1'b1},
      '{32'h1234_5678, 3'd6, 1'b1},
      '{32'h1234_5678, 3'd7, 1'b1},
      '{32'h0000_0000, 3'd4, 1'b1},
      '{32'hffff_ffff, 3'd0, 1'b0},
      '{32'hffff_ffff, 3'd7, 1'b0},
      '{32'hffff_ffff, 3'd3, 1'b1},
      '{32'ha5a5_a5a5, 3'd4, 1'b0},
      '{32'h5a5a_5a5a, 3'd4, 1'b0},
      '{32'h0102_0304, 3'd1, 1'b0},
      '{32'h8000_0000, 3'd0, 1'b1},
      '{32'hdead_beef, 3'd2, 1'b0},
      '{32'hcafe_f00d, 3'd4, 1'b1},
      '{32'h0000_0001, 3'd7, 1'b1}
   };

   crapwow_hash_32 DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // fold one accepted word into the predictor, queue a hash on the last word
   task automatic predict_hash(input logic [31:0] word, input logic [2:0] count,
                               input logic last);
      logic [63:0] prod;
      logic [31:0] eff, mask, h, k, t;
      eff = (!last || count > FULL_COUNT) ? 32'd4 : {29'd0, count};
      if (eff == 32'd4) begin
         if (!odd_word) begin
            prod = {32'd0, word} * {32'd0, MULT_N};
            acc_h ^= prod[31:0];
            acc_k ^= prod[63:32];
         end else begin
            prod = {32'd0, word} * {32'd0, MULT_M};
            acc_k ^= prod[31:0];
            acc_h ^= prod[63:32];
         end
         odd_word = ~odd_word;
      end else if (eff != 32'd0) begin
         mask = (32'd1 << (eff * 8)) - 32'd1;
         prod = {32'd0, word & mask} * {32'd0, MULT_M};
         acc_k ^= prod[31:0];
         acc_h ^= prod[63:32];
      end
      key_bytes += eff;
      if (last) begin
         // length-dependent start values, then the final n-mix
         h = acc_h ^ key_bytes;
         k = acc_k ^ (key_bytes + seed_reg + MULT_N);
         t = h ^ (k + MULT_N);
         prod = {32'd0, t} * {32'd0, MULT_N};
         h ^= prod[31:0];
         k ^= prod[63:32];
         expected_hashes.push_back(k ^ h);
         acc_h = '0;
         acc_k = '0;
         key_bytes = '0;
         odd_word = 1'b0;
      end
   endtask

   // drive one key word and hold it until the transaction completes
   task automatic send_word(input logic [31:0] word, input logic [2:0] count,
                            input logic last);
      req_tdata  <= {5'd0, count, word};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_hash(word, count, last);
      if (!calm && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   // wait for every queued hash, then let the mix pipeline go quiet
   task automatic settle;
      req_tvalid <= 1'b0;
      while (expected_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      csr_wdata <= value;
      csr_wen   <= 1'b1;
      @(posedge clock);
      csr_wen   <= 1'b0;
      seed_reg = value;
   endtask

   function automatic logic [31:0] random_word;
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // whole keys of random length; long keys now and then
   task automatic send_random_keys(input int unsigned n_items);
      int unsigned sent, words, i;
      sent = 0;
      while (sent < n_items) begin
         words = ($urandom_range(14) == 0) ? $urandom_range(60, 20) : $urandom_range(6);
         for (i = 0; i < words; i++)
            send_word(random_word(), 3'($urandom_range(7)), 1'b0);
         send_word(random_word(), 3'($urandom_range(7)), 1'b1);
         sent += words + 1;
      end
   endtask

   // result side: random stalls, none while calm
   always @(posedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
   end

   // compare each hash transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_hashes.size() == 0) begin
            $display("%0t: unexpected hash, expected none, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            if (rsp_tdata !== expected_hashes[0]) begin
               $display("%0t: hash mismatch, expected %h, actual %h",
                        $time, expected_hashes[0], rsp_tdata);
               error_count++;
            end
            void'(expected_hashes.pop_front());
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      logic [31:0] phase_seeds [6];
      int unsigned p, r;
      acc_h     = '0;
      acc_k     = '0;
      key_bytes = '0;
      odd_word  = 1'b0;
      seed_reg  = '0;
      phase_seeds = '{32'hffff_ffff, 32'h0000_0000, 32'h8000_0000,
                      $urandom, $urandom, 32'h0000_0001};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part with the seed from reset
      for (r = 0; r < N_DIRECTED; r++)
         send_word(directed_words[r].word, directed_words[r].count, directed_words[r].last);
      settle();

      // random keys under each seed; one phase runs with no idling at all
      for (p = 0; p < 6; p++) begin
         write_seed(phase_seeds[p]);
         calm = (p == 3);
         send_random_keys(122);
         settle();
         calm = 1'b0;
      end

      if (error_count == 0 && expected_hashes.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
